[rtl/core/vac_pkg.sv]
// Voice allocator package: sizes, codes, item structs and the queued command.
// Used by every module of synth_voice_allocator; depends on nothing.
`default_nettype none
package vac_pkg;

  localparam int VOICES      = 16;
  localparam int SLOT_W      = $clog2(VOICES);
  localparam int COUNT_W     = $clog2(VOICES + 1);
  localparam int AGE_W       = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [AGE_W-1:0]   age_t;
  typedef logic [QPTR_W-1:0]  qptr_t;
  typedef logic [QCNT_W-1:0]  qcnt_t;
  typedef logic [VOICES-1:0]  vmask_t;

  localparam age_t AGE_MAX = '1;

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_FINISHED = 2'd2,
    KIND_BEND     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ALLOC,
    OP_RELEASE,
    OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_COMMIT,
    B_RESULT
  } back_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  note_number;
    logic [15:0] voice_tag;
    logic [6:0]  velocity_level;
    logic [3:0]  finished_slot;
  } event_t;

  typedef struct packed {
    logic        allocated;
    logic [3:0]  slot;
    logic        stolen;
    logic [15:0] release_mask;
    logic [4:0]  active_count;
  } result_t;

  typedef struct packed {
    op_t         op;
    logic [6:0]  note;
    logic [15:0] tag;
    slot_t       fin_slot;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

[rtl/core/vac_front.sv]
// Front end: takes event items and turns them into queued commands.
// Depends on vac_pkg.
`default_nettype none
module vac_front (
  input  wire logic                   event_valid,
  output logic                        event_stall,
  input  wire vac_pkg::event_t        event_item,
  input  wire vac_pkg::queue_status_t qstat,
  output logic                        push,
  output vac_pkg::cmd_t               cmd
);

  always_comb begin
    cmd.note     = event_item.note_number;
    cmd.tag      = event_item.voice_tag;
    cmd.fin_slot = vac_pkg::slot_t'(event_item.finished_slot);
    case (event_item.kind)
      vac_pkg::KIND_NOTE_ON: begin
        cmd.op = (event_item.velocity_level != 7'd0) ? vac_pkg::OP_ALLOC : vac_pkg::OP_NONE;
      end
      vac_pkg::KIND_NOTE_OFF: begin
        cmd.op = vac_pkg::OP_RELEASE;
      end
      vac_pkg::KIND_FINISHED: begin
        cmd.op = (int'(event_item.finished_slot) < vac_pkg::VOICES) ?
                 vac_pkg::OP_FINISH : vac_pkg::OP_NONE;
      end
      default: begin
        cmd.op = vac_pkg::OP_NONE;
      end
    endcase
  end

  assign event_stall = qstat.full;
  assign push        = event_valid && !qstat.full;

endmodule
`default_nettype wire

[rtl/core/vac_queue.sv]
// Short command queue between front end and slot engine.
// Depends on vac_pkg.
`default_nettype none
module vac_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire vac_pkg::cmd_t cmd_in,
  input  wire logic          pop,
  output vac_pkg::cmd_t      head,
  output vac_pkg::queue_status_t qstat
);

  vac_pkg::cmd_t  store [vac_pkg::QUEUE_DEPTH];
  vac_pkg::qptr_t wr_ptr;
  vac_pkg::qptr_t rd_ptr;
  vac_pkg::qcnt_t count;

  function automatic vac_pkg::qptr_t bump(input vac_pkg::qptr_t p);
    vac_pkg::qptr_t r;
    if (p == vac_pkg::qptr_t'(vac_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + vac_pkg::qptr_t'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + vac_pkg::qcnt_t'(1);
      end else if (pop && !push) begin
        count <= count - vac_pkg::qcnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= cmd_in;
    end
  end

  assign head        = store[rd_ptr];
  assign qstat.full  = (count == vac_pkg::qcnt_t'(vac_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

endmodule
`default_nettype wire

[rtl/core/vac_back.sv]
// Slot engine: keeps per-slot state, scans slots for note-on and note-off,
// and holds the result register. Depends on vac_pkg.
`default_nettype none
module vac_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire vac_pkg::queue_status_t qstat,
  input  wire vac_pkg::cmd_t          head,
  output logic                        pop,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output vac_pkg::result_t            result_item
);

  vac_pkg::back_state_t state, state_next;

  vac_pkg::cmd_t   cur;
  vac_pkg::slot_t  idx;
  vac_pkg::vmask_t active;
  vac_pkg::vmask_t held;
  vac_pkg::vmask_t rel_mask;
  logic [6:0]      note_mem [vac_pkg::VOICES];
  logic [15:0]     tag_mem  [vac_pkg::VOICES];
  vac_pkg::age_t   age_mem  [vac_pkg::VOICES];
  vac_pkg::age_t   age_counter;
  vac_pkg::age_t   best_age;
  vac_pkg::slot_t  best_slot;
  vac_pkg::slot_t  free_slot;
  logic            found_free;
  vac_pkg::count_t active_count;
  logic            res_alloc;
  logic            res_stolen;
  vac_pkg::slot_t  res_slot;

  logic           out_free;
  logic           last;
  logic           scan;
  logic           commit;
  logic           load;
  logic           rel_hit;
  vac_pkg::slot_t chosen;

  assign out_free = !result_valid || !result_stall;
  assign last     = (idx == vac_pkg::slot_t'(vac_pkg::VOICES - 1));
  assign chosen   = found_free ? free_slot : best_slot;
  assign rel_hit  = active[idx] && held[idx] &&
                    (tag_mem[idx] == cur.tag || note_mem[idx] == cur.note);

  always_comb begin
    state_next = state;
    case (state)
      vac_pkg::B_IDLE: begin
        if (!qstat.empty) begin
          if (head.op == vac_pkg::OP_ALLOC || head.op == vac_pkg::OP_RELEASE) begin
            state_next = vac_pkg::B_SCAN;
          end else begin
            state_next = vac_pkg::B_RESULT;
          end
        end
      end
      vac_pkg::B_SCAN: begin
        if (last) begin
          state_next = (cur.op == vac_pkg::OP_ALLOC) ? vac_pkg::B_COMMIT : vac_pkg::B_RESULT;
        end
      end
      vac_pkg::B_COMMIT: begin
        state_next = vac_pkg::B_RESULT;
      end
      vac_pkg::B_RESULT: begin
        if (out_free) begin
          state_next = vac_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = vac_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    scan   = 1'b0;
    commit = 1'b0;
    load   = 1'b0;
    case (state)
      vac_pkg::B_IDLE:   pop    = !qstat.empty;
      vac_pkg::B_SCAN:   scan   = 1'b1;
      vac_pkg::B_COMMIT: commit = 1'b1;
      vac_pkg::B_RESULT: load   = out_free;
      default: begin
      end
    endcase
  end

  // control and reset-defined state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vac_pkg::B_IDLE;
      active       <= '0;
      held         <= '0;
      age_counter  <= '0;
      active_count <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < vac_pkg::VOICES; i++) begin
        age_mem[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (pop && head.op == vac_pkg::OP_FINISH && active[head.fin_slot]) begin
        active[head.fin_slot] <= 1'b0;
        active_count          <= active_count - vac_pkg::count_t'(1);
      end
      if (scan && cur.op == vac_pkg::OP_RELEASE && rel_hit) begin
        held[idx] <= 1'b0;
      end
      if (commit) begin
        active[chosen]  <= 1'b1;
        held[chosen]    <= 1'b1;
        age_mem[chosen] <= age_counter + vac_pkg::age_t'(1);
        age_counter     <= age_counter + vac_pkg::age_t'(1);
        if (found_free) begin
          active_count <= active_count + vac_pkg::count_t'(1);
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur        <= head;
      idx        <= '0;
      found_free <= 1'b0;
      free_slot  <= '0;
      best_age   <= vac_pkg::AGE_MAX;
      best_slot  <= '0;
      rel_mask   <= '0;
      res_alloc  <= 1'b0;
      res_stolen <= 1'b0;
      res_slot   <= '0;
    end
    if (scan) begin
      idx <= idx + vac_pkg::slot_t'(1);
      if (cur.op == vac_pkg::OP_ALLOC) begin
        if (!found_free && !active[idx]) begin
          found_free <= 1'b1;
          free_slot  <= idx;
        end
        if (age_mem[idx] < best_age) begin
          best_age  <= age_mem[idx];
          best_slot <= idx;
        end
      end else if (rel_hit) begin
        rel_mask[idx] <= 1'b1;
      end
    end
    if (commit) begin
      note_mem[chosen] <= cur.note;
      tag_mem[chosen]  <= cur.tag;
      res_alloc        <= 1'b1;
      res_stolen       <= !found_free;
      res_slot         <= chosen;
    end
    if (load) begin
      result_item.allocated    <= res_alloc;
      result_item.slot         <= 4'(res_slot);
      result_item.stolen       <= res_stolen;
      result_item.release_mask <= 16'(rel_mask);
      result_item.active_count <= 5'(active_count);
    end
  end

endmodule
`default_nettype wire

[rtl/core/synth_voice_allocator.sv]
// Top level of the polyphonic voice allocator with oldest-voice stealing.
// Depends on vac_pkg, vac_front, vac_queue and vac_back.
//
//   channel  valid         stall         item
//   input    event_valid   event_stall   event_item  (vac_pkg::event_t)
//   output   result_valid  result_stall  result_item (vac_pkg::result_t)
//
// Note-on and note-off run the one-slot-a-cycle scan with its single 64-bit age
// compare, and note-on then commits its slot; other items go straight to the result.
// A two-entry command queue takes items while the engine scans or waits.
// rst is synchronous; all slots come out inactive, ages and counter zero.
// A stalled result holds; the engine waits with its finished item until taken.
`default_nettype none
module synth_voice_allocator (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             event_valid,
  output logic                  event_stall,
  input  wire vac_pkg::event_t  event_item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output vac_pkg::result_t      result_item
);

  vac_pkg::queue_status_t qstat;
  vac_pkg::cmd_t          cmd;
  vac_pkg::cmd_t          head;
  logic                   push;
  logic                   pop;

  vac_front u_front (
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_item  (event_item),
    .qstat       (qstat),
    .push        (push),
    .cmd         (cmd)
  );

  vac_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  vac_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule
`default_nettype wire

[rtl/core/vac_checker.sv]
// Port-level checks on the voice allocator's result channel, bound to the top.
// Depends on vac_pkg and synth_voice_allocator.
`default_nettype none
module vac_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire vac_pkg::result_t result_item
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.allocated |->
      result_item.slot == 4'd0 && !result_item.stolen)
    else $error("slot or steal flag without allocation");

  a_mask_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.release_mask != 16'd0 |-> !result_item.allocated)
    else $error("release mask on a note-on item");

  a_steal_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.stolen |->
      result_item.allocated && result_item.active_count == 5'(vac_pkg::VOICES))
    else $error("steal while a slot was free");

endmodule

bind synth_voice_allocator vac_checker u_checker (.*);
`default_nettype wire

[sim/synth_voice_allocator_test.sv]
// Self-checking testbench for synth_voice_allocator: a directed table, then biased random
// note traffic in four idle/stall phases, checked item by item against a voice-state predictor.
// Depends on vac_pkg and the synth_voice_allocator RTL.
`default_nettype none
module synth_voice_allocator_test;

  localparam int QUIET_LIMIT   = 4000;
  localparam int ITEMS_A_PHASE = 500;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    vac_pkg::event_t  ev;
    logic             typed;
    vac_pkg::result_t want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             event_valid = 1'b0;
  logic             event_stall;
  vac_pkg::event_t  event_item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  vac_pkg::result_t result_item;

  // predicted voice state
  bit          v_active [vac_pkg::VOICES];
  bit          v_held   [vac_pkg::VOICES];
  bit [6:0]    v_note   [vac_pkg::VOICES];
  bit [15:0]   v_tag    [vac_pkg::VOICES];
  bit [6:0]    v_vel    [vac_pkg::VOICES];
  bit [63:0]   v_age    [vac_pkg::VOICES];
  bit [63:0]   age_clock;

  vac_pkg::result_t pending_results [$];
  int      err_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      quiet_cycles = 0;

  synth_voice_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_item   (event_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic vac_pkg::result_t apply_event(vac_pkg::event_t ev);
    vac_pkg::result_t res;
    int               chosen;
    int               live;
    vac_pkg::age_t    oldest;
    res = '0;
    case (ev.kind)
      vac_pkg::KIND_NOTE_ON: if (ev.velocity_level != 0) begin
        chosen = -1;
        for (int i = 0; i < vac_pkg::VOICES; i++)
          if (chosen < 0 && !v_active[i]) chosen = i;
        res.stolen = (chosen < 0);
        if (chosen < 0) begin
          chosen = 0;
          oldest = vac_pkg::AGE_MAX;
          for (int i = 0; i < vac_pkg::VOICES; i++)
            if (v_age[i] < oldest) begin
              oldest = v_age[i];
              chosen = i;
            end
        end
        v_active[chosen] = 1'b1;
        v_held[chosen]   = 1'b1;
        v_note[chosen]   = ev.note_number;
        v_tag[chosen]    = ev.voice_tag;
        v_vel[chosen]    = ev.velocity_level;
        age_clock        = age_clock + 64'd1;
        v_age[chosen]    = age_clock;
        res.allocated    = 1'b1;
        res.slot         = 4'(chosen);
      end
      vac_pkg::KIND_NOTE_OFF: begin
        for (int i = 0; i < vac_pkg::VOICES; i++)
          if (v_active[i] && v_held[i] &&
              (v_tag[i] == ev.voice_tag || v_note[i] == ev.note_number)) begin
            v_held[i] = 1'b0;
            if (i < $bits(res.release_mask)) res.release_mask[i] = 1'b1;
          end
      end
      vac_pkg::KIND_FINISHED: begin
        if (ev.finished_slot < vac_pkg::VOICES) v_active[ev.finished_slot] = 1'b0;
      end
      default: ;
    endcase
    live = 0;
    for (int i = 0; i < vac_pkg::VOICES; i++)
      if (v_active[i]) live++;
    res.active_count = 5'(live);
    return res;
  endfunction

  // mostly note traffic aimed at voices that are sounding, with some noise
  function automatic vac_pkg::event_t random_event();
    vac_pkg::event_t ev;
    int     roll;
    int     pick;
    int     candidates [$];
    ev.kind           = vac_pkg::KIND_BEND;
    ev.note_number    = ($urandom_range(2) != 0) ? 7'(56 + $urandom_range(15)) : 7'($urandom);
    ev.voice_tag      = ($urandom_range(2) != 0) ? 16'($urandom_range(31)) : 16'($urandom);
    ev.velocity_level = 7'($urandom_range(127, 1));
    ev.finished_slot  = 4'($urandom);
    roll = $urandom_range(99);
    if (roll < 40) begin
      ev.kind = vac_pkg::KIND_NOTE_ON;
      if ($urandom_range(9) == 0) ev.velocity_level = '0;
    end else if (roll < 68) begin
      ev.kind = vac_pkg::KIND_NOTE_OFF;
      for (int i = 0; i < vac_pkg::VOICES; i++)
        if (v_active[i] && v_held[i]) candidates.push_back(i);
      if (candidates.size() != 0 && $urandom_range(3) != 0) begin
        pick = candidates[$urandom_range(candidates.size() - 1)];
        if ($urandom_range(1) != 0) ev.voice_tag = v_tag[pick];
        else ev.note_number = v_note[pick];
      end
    end else if (roll < 92) begin
      ev.kind = vac_pkg::KIND_FINISHED;
      for (int i = 0; i < vac_pkg::VOICES; i++)
        if (v_active[i]) candidates.push_back(i);
      if (candidates.size() != 0 && $urandom_range(4) != 0)
        ev.finished_slot = 4'(candidates[$urandom_range(candidates.size() - 1)]);
    end
    return ev;
  endfunction

  function automatic dir_row_t dir_row(vac_pkg::kind_t k, int note, int tag, int vel, int fin,
                                        bit typed = 1'b0, vac_pkg::result_t want = '0);
    dir_row_t r;
    r.ev.kind           = k;
    r.ev.note_number    = 7'(note);
    r.ev.voice_tag      = 16'(tag);
    r.ev.velocity_level = 7'(vel);
    r.ev.finished_slot  = 4'(fin);
    r.typed             = typed;
    r.want              = want;
    return r;
  endfunction

  task automatic offer(input vac_pkg::event_t ev, input bit typed,
                       input vac_pkg::result_t want);
    vac_pkg::result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      event_valid <= 1'b0;
      @(posedge clk);
    end
    event_valid <= 1'b1;
    event_item  <= ev;
    @(posedge clk);
    while (event_stall) @(posedge clk);
    predicted = apply_event(ev);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_side
    vac_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing pending, expected none got %h", $time,
                   result_item);
        end else begin
          want = pending_results.pop_front();
          check_field("allocated", want.allocated, result_item.allocated);
          check_field("slot", want.slot, result_item.slot);
          check_field("stolen", want.stolen, result_item.stolen);
          check_field("release_mask", want.release_mask, result_item.release_mask);
          check_field("active_count", want.active_count, result_item.active_count);
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (event_valid && !event_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t directed [$];
    int       idle_plan  [4];
    int       stall_plan [4];
    idle_plan  = '{0, 57, 0, 22};
    stall_plan = '{0, 0, 57, 22};

    // empty allocator, then the ignored and no-op cases
    directed.push_back(dir_row(vac_pkg::KIND_NOTE_OFF, 0, 0, 0, 0, 1'b1, '0));
    directed.push_back(dir_row(vac_pkg::KIND_BEND, 127, 'hFFFF, 127, 15, 1'b1, '0));
    directed.push_back(dir_row(vac_pkg::KIND_FINISHED, 0, 'hFFFF, 0, 15, 1'b1, '0));
    directed.push_back(dir_row(vac_pkg::KIND_NOTE_ON, 127, 'hFFFF, 0, 15, 1'b1, '0));
    directed.push_back(dir_row(vac_pkg::KIND_NOTE_ON, 0, 0, 1, 0, 1'b1,
                               vac_pkg::result_t'{1'b1, 4'd0, 1'b0, 16'h0, 5'd1}));
    directed.push_back(dir_row(vac_pkg::KIND_NOTE_ON, 127, 'hFFFF, 127, 0, 1'b1,
                               vac_pkg::result_t'{1'b1, 4'd1, 1'b0, 16'h0, 5'd2}));
    for (int i = 2; i < vac_pkg::VOICES; i++)
      directed.push_back(dir_row(vac_pkg::KIND_NOTE_ON, i * 8, i, i, 0, 1'b1,
                                 vac_pkg::result_t'{1'b1, 4'(i), 1'b0, 16'h0, 5'(i + 1)}));
    // all full: oldest voice is stolen
    directed.push_back(dir_row(vac_pkg::KIND_NOTE_ON, 5, 'h1234, 64, 0, 1'b1,
                               vac_pkg::result_t'{1'b1, 4'd0, 1'b1, 16'h0, 5'd16}));
    directed.push_back(dir_row(vac_pkg::KIND_NOTE_OFF, 16, 3, 0, 0));
    directed.push_back(dir_row(vac_pkg::KIND_NOTE_OFF, 127, 'hFFFF, 0, 0));
    directed.push_back(dir_row(vac_pkg::KIND_FINISHED, 0, 0, 0, 3));
    directed.push_back(dir_row(vac_pkg::KIND_FINISHED, 0, 0, 0, 3));
    directed.push_back(dir_row(vac_pkg::KIND_NOTE_ON, 1, 2, 100, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) offer(directed[i].ev, directed[i].typed, directed[i].want);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      repeat (ITEMS_A_PHASE) offer(random_event(), 1'b0, '0);
    end

    event_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
